// ===== rtl/pcpd_pkg.sv =====
// Package: shared widths, op codes and register indexes of the patch column post decoder.
`default_nettype none
package pcpd_pkg;

  localparam int unsigned MaxSideDefault = 1024;
  localparam int unsigned PaletteSize    = 256;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned COLUMN_W = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned RGB_W    = 24;
  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned COLOUR_W = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TEX_W    = 11;

  typedef enum logic [OP_W-1:0] {
    OP_PALETTE = 2'd0,
    OP_START   = 2'd1,
    OP_DATA    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_OFFSET = 2'd0,
    CFG_Y_OFFSET = 2'd1,
    CFG_TEX_W    = 2'd2,
    CFG_TEX_H    = 2'd3
  } cfg_idx_e;

  localparam logic [BYTE_W-1:0] END_MARK = 8'hFF;
  localparam logic [BYTE_W-1:0] ALPHA    = 8'hFF;

endpackage
`default_nettype wire

// ===== rtl/pcpd_if.sv =====
// Interfaces: input word channel and result word channel.
`default_nettype none
interface pcpd_in_if;
  logic                            valid;
  logic                            ready;
  logic [pcpd_pkg::OP_W-1:0]       op;
  logic [pcpd_pkg::COLUMN_W-1:0]   column;
  logic [pcpd_pkg::BYTE_W-1:0]     data_byte;
  logic [pcpd_pkg::BYTE_W-1:0]     palette_slot;
  logic [pcpd_pkg::BYTE_W-1:0]     red;
  logic [pcpd_pkg::BYTE_W-1:0]     green;
  logic [pcpd_pkg::BYTE_W-1:0]     blue;

  modport source (output valid, op, column, data_byte, palette_slot, red, green, blue,
                  input ready);
  modport sink   (input valid, op, column, data_byte, palette_slot, red, green, blue,
                  output ready);
endinterface

interface pcpd_out_if;
  logic                            valid;
  logic                            ready;
  logic                            write_valid;
  logic [pcpd_pkg::ADDR_W-1:0]     pixel_address;
  logic [pcpd_pkg::COLOUR_W-1:0]   pixel_colour;
  logic                            column_done;

  modport source (output valid, write_valid, pixel_address, pixel_colour, column_done,
                  input ready);
  modport sink   (input valid, write_valid, pixel_address, pixel_colour, column_done,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/pcpd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pcpd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/patch_column_post_decoder.sv =====
// Patch column post decoder: parses column posts and emits clipped texture pixel writes.
//
// Channels: in_i takes one word per handshake (op 0 palette write, op 1 start column,
// op 2 post stream byte); out_o gives one result word per pixel inside the texture
// (write_valid, linear address, ARGB colour) or per end-of-column marker (column_done).
// Config: cfg_we_i writes register cfg_idx_i (x offset, y offset, width, height) with
// cfg_wdata_i; write only while no words are in flight.
// Throughput: one input word per cycle while out_o is not held off, with no gaps between
// posts or columns. A result is registered twice on its way to out_o: the palette RAM
// read fills the read stage, then the row-times-stride multiply-add fills the output
// register.
// Stall: when out_o is held off, the output register keeps its word and the read
// stage behind it still fills; in_i.ready drops only when both are full.
// Reset: the parser goes to the column-ended state, counters and config registers clear,
// the pipeline empties. The palette RAM is not cleared; every index used by column
// data must have been written first.
`default_nettype none
module patch_column_post_decoder #(
  parameter int unsigned MAX_SIDE = pcpd_pkg::MaxSideDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [pcpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [pcpd_pkg::CFG_W-1:0]      cfg_wdata_i,
  pcpd_in_if.sink                              in_i,
  pcpd_out_if.source                           out_o
);
  import pcpd_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_SIDE);
  localparam int unsigned SIDEW = $clog2(MAX_SIDE + 1);
  localparam int unsigned PW    = (CW + SIDEW + 1 > ADDR_W) ? CW + SIDEW + 1 : ADDR_W;
  localparam int unsigned PALW  = $clog2(PaletteSize);
  localparam int unsigned POSW  = 18;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_TOP  = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_PAD1 = 6'b001000,
    PH_DATA = 6'b010000,
    PH_PAD2 = 6'b100000
  } phase_e;

  // config
  logic [CFG_W-1:0] x_off_q, y_off_q;
  logic [TEX_W-1:0] tex_w_q, tex_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q <= '0;
      y_off_q <= '0;
      tex_w_q <= '0;
      tex_h_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_X_OFFSET: x_off_q <= cfg_wdata_i;
        CFG_Y_OFFSET: y_off_q <= cfg_wdata_i;
        CFG_TEX_W:    tex_w_q <= cfg_wdata_i[TEX_W-1:0];
        CFG_TEX_H:    tex_h_q <= cfg_wdata_i[TEX_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SIDEW-1:0] w_clip, h_clip;
  assign w_clip = (32'(tex_w_q) > 32'(MAX_SIDE)) ? SIDEW'(MAX_SIDE) : SIDEW'(tex_w_q);
  assign h_clip = (32'(tex_h_q) > 32'(MAX_SIDE)) ? SIDEW'(MAX_SIDE) : SIDEW'(tex_h_q);

  // pipeline handshake
  logic s1_valid_q, s1_valid_d;
  logic o_valid_q, o_valid_d;
  logic s1_adv, in_ready, acc;

  assign s1_adv   = s1_valid_q && (!o_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || s1_adv;
  assign acc      = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // parser
  phase_e            phase_q, phase_d;
  logic [COLUMN_W-1:0] col_q, col_d;
  logic [BYTE_W-1:0] top_q, top_d, len_q, len_d, row_q, row_d;
  logic [BYTE_W-1:0] row_inc;
  logic              is_data, done_ev, hit;
  logic signed [POSW-1:0] tx, ty;
  logic              tx_in, ty_in;

  assign is_data = acc && (op_e'(in_i.op) == OP_DATA);
  assign row_inc = row_q + BYTE_W'(1);

  assign tx = POSW'($signed(x_off_q)) + $signed({2'b00, col_q});
  assign ty = POSW'($signed(y_off_q)) + $signed({10'd0, top_q}) + $signed({10'd0, row_q});
  assign tx_in = !tx[POSW-1] && (tx[POSW-2:0] < (POSW-1)'(w_clip));
  assign ty_in = !ty[POSW-1] && (ty[POSW-2:0] < (POSW-1)'(h_clip));

  assign done_ev = is_data && (phase_q == PH_TOP) && (in_i.data_byte == END_MARK);
  assign hit     = is_data && (phase_q == PH_DATA) && tx_in && ty_in;

  always_comb begin
    phase_d = phase_q;
    col_d   = col_q;
    top_d   = top_q;
    len_d   = len_q;
    row_d   = row_q;
    if (acc && op_e'(in_i.op) == OP_START) begin
      col_d   = in_i.column;
      phase_d = PH_TOP;
      top_d   = '0;
      len_d   = '0;
      row_d   = '0;
    end else if (is_data) begin
      case (phase_q)
        PH_TOP: begin
          if (in_i.data_byte == END_MARK) begin
            phase_d = PH_IDLE;
          end else begin
            top_d   = in_i.data_byte;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          len_d   = in_i.data_byte;
          phase_d = PH_PAD1;
        end
        PH_PAD1: begin
          row_d   = '0;
          phase_d = (len_q == '0) ? PH_PAD2 : PH_DATA;
        end
        PH_DATA: begin
          row_d = row_inc;
          if (row_inc >= len_q) begin
            phase_d = PH_PAD2;
          end
        end
        PH_PAD2: phase_d = PH_TOP;
        default: phase_d = phase_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      col_q   <= '0;
      top_q   <= '0;
      len_q   <= '0;
      row_q   <= '0;
    end else begin
      phase_q <= phase_d;
      col_q   <= col_d;
      top_q   <= top_d;
      len_q   <= len_d;
      row_q   <= row_d;
    end
  end

  // palette RAM; read data lines up with the read stage
  logic [RGB_W-1:0] ram_rdata;

  pcpd_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PaletteSize)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (acc && op_e'(in_i.op) == OP_PALETTE),
    .waddr_i (PALW'(in_i.palette_slot)),
    .wdata_i ({in_i.red, in_i.green, in_i.blue}),
    .re_i    (acc),
    .raddr_i (PALW'(in_i.data_byte)),
    .rdata_o (ram_rdata)
  );

  // read stage
  logic             s1_done_q;
  logic [CW-1:0]    s1_tx_q, s1_ty_q;
  logic [SIDEW-1:0] s1_w_q;

  assign s1_valid_d = (hit || done_ev) ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_done_q <= done_ev;
      s1_tx_q   <= CW'(tx[POSW-2:0]);
      s1_ty_q   <= CW'(ty[POSW-2:0]);
      s1_w_q    <= w_clip;
    end
  end

  // output stage
  logic [PW-1:0]       lin_addr;
  logic                o_wr_q, o_done_q;
  logic [ADDR_W-1:0]   o_addr_q;
  logic [COLOUR_W-1:0] o_col_q;

  assign lin_addr = PW'(s1_ty_q) * PW'(s1_w_q) + PW'(s1_tx_q);
  assign o_valid_d = s1_adv ? 1'b1 : (out_o.ready ? 1'b0 : o_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else begin
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      o_wr_q   <= !s1_done_q;
      o_done_q <= s1_done_q;
      o_addr_q <= s1_done_q ? '0 : lin_addr[ADDR_W-1:0];
      o_col_q  <= s1_done_q ? '0 : {ALPHA, ram_rdata};
    end
  end

  assign out_o.valid         = o_valid_q;
  assign out_o.write_valid   = o_wr_q;
  assign out_o.pixel_address = o_addr_q;
  assign out_o.pixel_colour  = o_col_q;
  assign out_o.column_done   = o_done_q;

  // checks
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.write_valid != out_o.column_done))
    else $error("result word is neither or both of pixel write and column done");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.column_done |-> (out_o.pixel_address == '0) &&
                                         (out_o.pixel_colour == '0))
    else $error("column done word carries pixel payload");

  a_rdata_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> $stable(ram_rdata))
    else $error("palette read data lost while read stage stalled");

  a_start_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (op_e'(in_i.op) == OP_START) |=> (phase_q == PH_TOP))
    else $error("start column did not restart parsing at top offset");

endmodule
`default_nettype wire

// ===== tb/patch_column_post_decoder_tb.sv =====
// Testbench: random and directed column post streams against a cycle-free pixel predictor.
`timescale 1ns / 1ps
module patch_column_post_decoder_tb;
  import pcpd_pkg::*;

  typedef enum logic [2:0] {
    PARSE_IDLE, PARSE_TOP, PARSE_LEN, PARSE_PAD1, PARSE_DATA, PARSE_PAD2
  } parse_e;

  typedef struct packed {
    op_e                 op;
    logic [COLUMN_W-1:0] column;
    logic [BYTE_W-1:0]   data_byte;
    logic [BYTE_W-1:0]   palette_slot;
    logic [BYTE_W-1:0]   red;
    logic [BYTE_W-1:0]   green;
    logic [BYTE_W-1:0]   blue;
  } in_word_t;

  typedef struct packed {
    logic                write_valid;
    logic [ADDR_W-1:0]   pixel_address;
    logic [COLOUR_W-1:0] pixel_colour;
    logic                column_done;
  } pixel_word_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           cfg_we_i;
  cfg_idx_e       cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  pcpd_in_if  in_if ();
  pcpd_out_if out_if ();

  patch_column_post_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [RGB_W-1:0]    palette_rgb [PaletteSize];
  bit                  palette_set [PaletteSize];
  logic [BYTE_W-1:0]   written_slots [$];
  parse_e              parse_phase;
  logic [COLUMN_W-1:0] cur_col;
  logic [BYTE_W-1:0]   post_top, post_len, post_row;
  logic signed [15:0]  cfg_x, cfg_y;
  logic [TEX_W-1:0]    cfg_w, cfg_h;

  in_word_t    stream_words [$];
  pixel_word_t expected_writes [$];
  int          phase_words;
  int          errors;

  bit in_fire;
  int in_gap, in_calm, out_stall, out_calm;

  function automatic int side_limit(logic [TEX_W-1:0] v);
    return (v > MaxSideDefault) ? MaxSideDefault : int'(v);
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic composite_word(in_word_t w);
    pixel_word_t px;
    int tx, ty, wd, ht, addr;
    px = '0;
    case (w.op)
      OP_PALETTE: begin
        if (!palette_set[w.palette_slot]) written_slots.push_back(w.palette_slot);
        palette_set[w.palette_slot] = 1'b1;
        palette_rgb[w.palette_slot] = {w.red, w.green, w.blue};
      end
      OP_START: begin
        cur_col = w.column;
        parse_phase = PARSE_TOP;
        post_top = '0;
        post_len = '0;
        post_row = '0;
      end
      OP_DATA: begin
        case (parse_phase)
          PARSE_TOP: begin
            if (w.data_byte == END_MARK) begin
              parse_phase = PARSE_IDLE;
              px.column_done = 1'b1;
              expected_writes.push_back(px);
            end else begin
              post_top = w.data_byte;
              parse_phase = PARSE_LEN;
            end
          end
          PARSE_LEN: begin
            post_len = w.data_byte;
            parse_phase = PARSE_PAD1;
          end
          PARSE_PAD1: begin
            post_row = '0;
            parse_phase = (post_len == 0) ? PARSE_PAD2 : PARSE_DATA;
          end
          PARSE_DATA: begin
            tx = cfg_x + int'(cur_col);
            ty = cfg_y + int'(post_top) + int'(post_row);
            wd = side_limit(cfg_w);
            ht = side_limit(cfg_h);
            post_row = post_row + 8'd1;
            if (post_row >= post_len) parse_phase = PARSE_PAD2;
            if (tx >= 0 && tx < wd && ty >= 0 && ty < ht) begin
              addr = ty * wd + tx;
              px.write_valid = 1'b1;
              px.pixel_address = addr[ADDR_W-1:0];
              px.pixel_colour = {ALPHA, palette_rgb[w.data_byte]};
              expected_writes.push_back(px);
            end
          end
          PARSE_PAD2: parse_phase = PARSE_TOP;
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  function automatic in_word_t any_word(op_e op);
    in_word_t w;
    w.op = op;
    w.column = COLUMN_W'($urandom);
    w.data_byte = BYTE_W'($urandom);
    w.palette_slot = BYTE_W'($urandom);
    w.red = BYTE_W'($urandom);
    w.green = BYTE_W'($urandom);
    w.blue = BYTE_W'($urandom);
    return w;
  endfunction

  // an index byte must never name a colour slot that was never loaded
  task automatic issue_word(in_word_t w);
    if (w.op == OP_DATA && parse_phase == PARSE_DATA && !palette_set[w.data_byte])
      w.data_byte = written_slots[$urandom_range(0, written_slots.size() - 1)];
    composite_word(w);
    stream_words.push_back(w);
    phase_words++;
  endtask

  task automatic put_palette(logic [BYTE_W-1:0] slot, logic [RGB_W-1:0] rgb);
    in_word_t w;
    w = any_word(OP_PALETTE);
    w.palette_slot = slot;
    {w.red, w.green, w.blue} = rgb;
    issue_word(w);
  endtask

  task automatic put_start(logic [COLUMN_W-1:0] col);
    in_word_t w;
    w = any_word(OP_START);
    w.column = col;
    issue_word(w);
  endtask

  task automatic put_byte(logic [BYTE_W-1:0] b);
    in_word_t w;
    w = any_word(OP_DATA);
    w.data_byte = b;
    issue_word(w);
  endtask

  task automatic put_post(logic [BYTE_W-1:0] top, logic [BYTE_W-1:0] len);
    int i;
    put_byte(top);
    put_byte(len);
    put_byte(BYTE_W'($urandom));
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 4) != 0)
        put_byte(written_slots[$urandom_range(0, written_slots.size() - 1)]);
      else
        put_byte(BYTE_W'($urandom));
    end
    put_byte(BYTE_W'($urandom));
  endtask

  task automatic put_random_column();
    int c, t, n, len, wd, ht, k;
    wd = side_limit(cfg_w);
    ht = side_limit(cfg_h);
    c = $urandom_range(0, wd + 2);
    c = c - 1 - cfg_x;
    if ($urandom_range(0, 4) == 0) c = $urandom_range(0, 16'hFFFF);
    put_start(c[COLUMN_W-1:0]);
    n = $urandom_range(0, 3);
    for (k = 0; k < n; k++) begin
      t = $urandom_range(0, ht + 2);
      t = t - 2 - cfg_y;
      if (t < 0 || t > 254 || $urandom_range(0, 3) == 0) t = $urandom_range(0, 254);
      len = $urandom_range(0, 99);
      if (len < 70) len = $urandom_range(0, 6);
      else if (len < 97) len = $urandom_range(7, 20);
      else len = $urandom_range(100, 255);
      put_post(t[BYTE_W-1:0], len[BYTE_W-1:0]);
    end
    case ($urandom_range(0, 9))
      0: ;  // left open, next start restarts the parser
      1: repeat ($urandom_range(1, 3)) put_byte(BYTE_W'($urandom));
      default: put_byte(END_MARK);
    endcase
  endtask

  task automatic put_random_words(int target);
    phase_words = 0;
    while (phase_words < target) begin
      case ($urandom_range(0, 19))
        0, 1: put_palette(BYTE_W'($urandom), RGB_W'($urandom));
        2: issue_word(any_word(OP_NONE));
        default: put_random_column();
      endcase
    end
  endtask

  task automatic load_config(int x, int y, int w, int h);
    cfg_x = x[15:0];
    cfg_y = y[15:0];
    cfg_w = w[TEX_W-1:0];
    cfg_h = h[TEX_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_X_OFFSET;
    cfg_wdata_i <= cfg_x;
    @(negedge clk_i);
    cfg_idx_i <= CFG_Y_OFFSET;
    cfg_wdata_i <= cfg_y;
    @(negedge clk_i);
    cfg_idx_i <= CFG_TEX_W;
    cfg_wdata_i <= {5'($urandom), cfg_w};
    @(negedge clk_i);
    cfg_idx_i <= CFG_TEX_H;
    cfg_wdata_i <= {5'($urandom), cfg_h};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    while (stream_words.size() != 0 || in_if.valid) @(posedge clk_i);
    while (expected_writes.size() != 0 && waited < 4000) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_writes.size() != 0) begin
      $display("%0t ERROR: %0d words missing, next expected %h", $time,
               expected_writes.size(), expected_writes[0]);
      errors++;
      expected_writes.delete();
    end
    repeat (8) @(posedge clk_i);
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_fire)) begin
      if (in_gap > 0) begin
        in_if.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (stream_words.size() != 0) begin
        in_word_t w;
        w = stream_words.pop_front();
        in_if.valid <= 1'b1;
        in_if.op <= w.op;
        in_if.column <= w.column;
        in_if.data_byte <= w.data_byte;
        in_if.palette_slot <= w.palette_slot;
        in_if.red <= w.red;
        in_if.green <= w.green;
        in_if.blue <= w.blue;
        if (in_calm > 0) begin
          in_calm <= in_calm - 1;
          in_gap <= 0;
        end else begin
          in_gap <= idle_length();
          if ($urandom_range(0, 49) == 0) in_calm <= $urandom_range(20, 80);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_stall > 0) begin
        out_if.ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        out_if.ready <= 1'b1;
        if (out_calm > 0) begin
          out_calm <= out_calm - 1;
        end else begin
          out_stall <= idle_length();
          if ($urandom_range(0, 49) == 0) out_calm <= $urandom_range(20, 80);
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : result_check
    pixel_word_t want;
    in_fire <= in_if.valid && in_if.ready;
    if (out_if.valid && out_if.ready) begin
      if (expected_writes.size() == 0) begin
        $display("%0t ERROR: unexpected word wv=%b addr=%h colour=%h done=%b", $time,
                 out_if.write_valid, out_if.pixel_address, out_if.pixel_colour,
                 out_if.column_done);
        errors++;
      end else begin
        want = expected_writes.pop_front();
        if (out_if.write_valid !== want.write_valid) begin
          $display("%0t ERROR: write_valid exp %b got %b", $time,
                   want.write_valid, out_if.write_valid);
          errors++;
        end
        if (out_if.pixel_address !== want.pixel_address) begin
          $display("%0t ERROR: pixel_address exp %h got %h", $time,
                   want.pixel_address, out_if.pixel_address);
          errors++;
        end
        if (out_if.pixel_colour !== want.pixel_colour) begin
          $display("%0t ERROR: pixel_colour exp %h got %h", $time,
                   want.pixel_colour, out_if.pixel_colour);
          errors++;
        end
        if (out_if.column_done !== want.column_done) begin
          $display("%0t ERROR: column_done exp %b got %b", $time,
                   want.column_done, out_if.column_done);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int x, y, w, h;
    in_if.valid = 1'b0;
    in_if.op = OP_NONE;
    in_if.column = '0;
    in_if.data_byte = '0;
    in_if.palette_slot = '0;
    in_if.red = '0;
    in_if.green = '0;
    in_if.blue = '0;
    out_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_X_OFFSET;
    cfg_wdata_i = '0;
    parse_phase = PARSE_IDLE;
    cur_col = '0;
    post_top = '0;
    post_len = '0;
    post_row = '0;
    cfg_x = '0;
    cfg_y = '0;
    cfg_w = '0;
    cfg_h = '0;
    errors = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset config: zero-sized texture, only end markers come out
    put_byte(8'h3C);
    issue_word(any_word(OP_NONE));
    put_palette(8'h00, 24'h000000);
    put_palette(8'hFF, 24'hFFFFFF);
    put_palette(8'h5A, 24'hA55AC3);
    put_palette(8'hA5, 24'h5AA53C);
    put_start(16'hFFFF);
    put_byte(END_MARK);
    settle();

    load_config(0, 0, 8, 8);
    // post crossing the bottom edge, then a zero-length post
    put_start(16'd0);
    put_byte(8'd6);
    put_byte(8'd3);
    put_byte(8'hFF);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'h5A);
    put_byte(8'h00);
    put_byte(8'd2);
    put_byte(8'd0);
    put_byte(8'h11);
    put_byte(8'h22);
    put_byte(END_MARK);
    // restart mid-column, last column inside
    put_start(16'd5);
    put_byte(8'd1);
    put_start(16'd7);
    put_byte(8'd0);
    put_byte(8'd1);
    put_byte(8'h00);
    put_byte(8'hA5);
    put_byte(8'h00);
    put_byte(END_MARK);
    settle();

    load_config(-3, -2, 16, 12);
    put_random_words(90);
    settle();
    load_config(0, 0, 1024, 1024);
    put_random_words(100);
    settle();
    load_config(32767, -32768, 2047, 2047);
    put_random_words(40);
    settle();
    load_config(-32768, -200, 1025, 1100);
    put_random_words(70);
    settle();
    load_config(5, 0, 1, 1);
    put_random_words(60);
    settle();
    repeat (3) begin
      x = $urandom_range(0, 80);
      y = $urandom_range(0, 80);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 64);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 64);
      load_config(x - 40, y - 40, w, h);
      put_random_words(80);
      settle();
    end

    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
